// ===== rtl/ptts_pkg.sv =====
// Package for the periodic task tick scheduler.
// Holds field widths, action codes and the table entry type.
// Used by the interfaces, the entry table and the top level.
package ptts_pkg;

   // Default number of table slots.
   localparam int SLOTS_DEFAULT = 8;

   // Payload field widths.
   localparam int PERIOD_W = 32;
   localparam int TICK_W   = 32;
   localparam int MASK_W   = 8;
   localparam int SLOT_W   = 3;

   // Action codes carried on the request channel.
   localparam logic ACT_TICK = 1'b0;
   localparam logic ACT_ADD  = 1'b1;

   // One table entry: the period and the tick at which it last fired.
   typedef struct packed {
      logic [PERIOD_W-1:0] period;
      logic [TICK_W-1:0]   last_fired;
   } entry_type;

endpackage

// ===== rtl/ptts_if.sv =====
// Request and response channel interfaces of the tick scheduler.
// Each carries valid, ready and the item payload; widths come from ptts_pkg.
interface ptts_req_if;
   logic                          valid;
   logic                          ready;
   logic                          action;
   logic [ptts_pkg::PERIOD_W-1:0] period_ticks;
   logic                          has_handler;

   modport source (output valid, output action, output period_ticks,
                   output has_handler, input ready);
   modport sink   (input valid, input action, input period_ticks,
                   input has_handler, output ready);
endinterface

interface ptts_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [ptts_pkg::MASK_W-1:0] fire_mask;
   logic                        add_accepted;
   logic [ptts_pkg::SLOT_W-1:0] assigned_slot;
   logic [ptts_pkg::TICK_W-1:0] tick_now;

   modport source (output valid, output fire_mask, output add_accepted,
                   output assigned_slot, output tick_now, input ready);
   modport sink   (input valid, input fire_mask, input add_accepted,
                   input assigned_slot, input tick_now, output ready);
endinterface

// ===== rtl/ptts_table.sv =====
// Task table memory: one write port and one read port, read data registered.
// Stores ptts_pkg::entry_type words; no reset, entries are valid once written.
module ptts_table #(
   parameter int DEPTH  = ptts_pkg::SLOTS_DEFAULT,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                clock,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   output ptts_pkg::entry_type rd_data,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  ptts_pkg::entry_type wr_data
);

   ptts_pkg::entry_type mem [DEPTH];
   ptts_pkg::entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port; the read data is registered.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/periodic_task_tick_scheduler.sv =====
// Periodic task tick scheduler, top level.
// Request channel req_ch: action selects a tick or an add. An add stores
// period_ticks in the next free slot when has_handler is set and the table
// has room. A tick bumps the 32-bit counter and then walks the stored
// entries in slot order, firing each one whose elapsed time reaches its
// period and recording the counter as its new last-fired tick.
// Response channel rsp_ch: one item per request with the fire mask (slots
// 0 to 7), the add status, the assigned slot and the counter value.
// Sequence: an add, or a tick with no stored entries, goes from acceptance
// straight to the done state, which loads the response once the output
// register is free. A tick over stored entries first walks them, paced
// by the table's single read port: one entry is read per cycle and its
// write-back overlaps the next read.
// The request side is ready only while the sequencer is idle. A finished
// response waits in the output register, so the next request is taken while
// the receiver stalls; that request then holds in its final state until the
// output register frees up.
// Reset clears the counter, the entry count and the handshake state; the
// table itself needs no clearing since only written slots are ever read.
module periodic_task_tick_scheduler #(
   parameter int TASK_SLOTS = ptts_pkg::SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   ptts_req_if.sink    req_ch,
   ptts_rsp_if.source  rsp_ch
);

   localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int CNT_W = $clog2(TASK_SLOTS + 1);
   localparam int EXT_W = (CNT_W > ptts_pkg::SLOT_W) ? CNT_W : ptts_pkg::SLOT_W;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WALK = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type                     state_ff, state_in;
   logic [ptts_pkg::TICK_W-1:0]   counter_ff, counter_in;
   logic [CNT_W-1:0]              total_ff, total_in;
   logic [CNT_W-1:0]              rd_idx_ff, rd_idx_in;
   logic                          pend_ff, pend_in;
   logic [IDX_W-1:0]              pend_idx_ff, pend_idx_in;
   logic [ptts_pkg::MASK_W-1:0]   mask_ff, mask_in;
   logic                          acc_ff, acc_in;
   logic [ptts_pkg::SLOT_W-1:0]   slot_ff, slot_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [ptts_pkg::MASK_W-1:0]   rsp_mask_ff, rsp_mask_in;
   logic                          rsp_acc_ff, rsp_acc_in;
   logic [ptts_pkg::SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [ptts_pkg::TICK_W-1:0]   rsp_tick_ff, rsp_tick_in;

   logic                          rd_en;
   logic [IDX_W-1:0]              rd_addr;
   ptts_pkg::entry_type           rd_data;
   logic                          wr_en;
   logic [IDX_W-1:0]              wr_addr;
   ptts_pkg::entry_type           wr_data;

   logic                          issue;
   logic [ptts_pkg::TICK_W-1:0]   elapsed;
   logic [EXT_W-1:0]              total_ext;
   logic [EXT_W-1:0]              pend_ext;

   // Entry table.
   ptts_table #(
      .DEPTH  (TASK_SLOTS),
      .ADDR_W (IDX_W)
   ) u_table (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   assign req_ch.ready        = (state_ff == ST_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.fire_mask    = rsp_mask_ff;
   assign rsp_ch.add_accepted = rsp_acc_ff;
   assign rsp_ch.assigned_slot = rsp_slot_ff;
   assign rsp_ch.tick_now     = rsp_tick_ff;

   assign total_ext = EXT_W'(total_ff);
   assign pend_ext  = EXT_W'(pend_idx_ff);
   assign elapsed   = counter_ff - rd_data.last_fired;

   // Sequencer: add in one step, tick as a read-compare-write walk.
   always_comb begin
      state_in     = state_ff;
      counter_in   = counter_ff;
      total_in     = total_ff;
      rd_idx_in    = rd_idx_ff;
      pend_in      = 1'b0;
      pend_idx_in  = pend_idx_ff;
      mask_in      = mask_ff;
      acc_in       = acc_ff;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_mask_in  = rsp_mask_ff;
      rsp_acc_in   = rsp_acc_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_tick_in  = rsp_tick_ff;
      rd_en        = 1'b0;
      rd_addr      = rd_idx_ff[IDX_W-1:0];
      wr_en        = 1'b0;
      wr_addr      = pend_idx_ff;
      wr_data      = '{period: rd_data.period, last_fired: counter_ff};
      issue        = 1'b0;

      // The receiver drains the output register.
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               mask_in = '0;
               acc_in  = 1'b0;
               slot_in = '0;
               if (req_ch.action == ptts_pkg::ACT_TICK) begin
                  counter_in = counter_ff + 1'b1;
                  rd_idx_in  = '0;
                  state_in   = (total_ff == '0) ? ST_DONE : ST_WALK;
               end else begin
                  if (req_ch.has_handler && (total_ff < CNT_W'(TASK_SLOTS))) begin
                     wr_en    = 1'b1;
                     wr_addr  = total_ff[IDX_W-1:0];
                     wr_data  = '{period: req_ch.period_ticks, last_fired: '0};
                     total_in = total_ff + 1'b1;
                     acc_in   = 1'b1;
                     slot_in  = total_ext[ptts_pkg::SLOT_W-1:0];
                  end
                  state_in = ST_DONE;
               end
            end
         end
         ST_WALK: begin
            // Read the next entry while the previous one is checked.
            issue = (rd_idx_ff < total_ff);
            if (issue) begin
               rd_en     = 1'b1;
               rd_idx_in = rd_idx_ff + 1'b1;
            end
            pend_in     = issue;
            pend_idx_in = rd_idx_ff[IDX_W-1:0];
            // Check the entry read last cycle and write back on a fire.
            if (pend_ff && (elapsed >= rd_data.period)) begin
               wr_en = 1'b1;
               if (int'(pend_idx_ff) < ptts_pkg::MASK_W) begin
                  mask_in[pend_ext[ptts_pkg::SLOT_W-1:0]] = 1'b1;
               end
            end
            if (!issue) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_mask_in  = mask_ff;
               rsp_acc_in   = acc_ff;
               rsp_slot_in  = slot_ff;
               rsp_tick_in  = counter_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         counter_ff   <= '0;
         total_ff     <= '0;
         rd_idx_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         counter_ff   <= counter_in;
         total_ff     <= total_in;
         rd_idx_ff    <= rd_idx_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pend_idx_ff <= pend_idx_in;
      mask_ff     <= mask_in;
      acc_ff      <= acc_in;
      slot_ff     <= slot_in;
      rsp_mask_ff <= rsp_mask_in;
      rsp_acc_ff  <= rsp_acc_in;
      rsp_slot_ff <= rsp_slot_in;
      rsp_tick_ff <= rsp_tick_in;
   end

   // A write-back never targets the entry being read in the same cycle.
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_en) |-> (rd_addr != wr_addr))
      else $error("table read and write hit the same entry");

   // The entry count never exceeds the table size.
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CNT_W'(TASK_SLOTS))
      else $error("entry count beyond table size");

   // An entry is checked only in the cycle after its read was issued.
   a_read_pairing: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> $past(rd_en))
      else $error("entry checked without a preceding read");

   // A valid add with room grows the table by one and reports acceptance.
   a_add_grows: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && (req_ch.action == ptts_pkg::ACT_ADD) &&
       req_ch.has_handler && (total_ff < CNT_W'(TASK_SLOTS)))
      |=> ((total_ff == $past(total_ff) + 1'b1) && acc_ff))
      else $error("accepted add did not grow the table");

endmodule
